// ----- src/rgb_box_blur_3x3_defines.svh -----
// Assertion helpers shared by the blur RTL.
`ifndef RGB_BOX_BLUR_3X3_DEFINES_SVH
`define RGB_BOX_BLUR_3X3_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define BBX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define BBX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bbx_pkg.sv -----
package bbx_pkg;

    localparam int DATA_W       = 8;
    localparam int PIX_W        = 3 * DATA_W;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int ROW_W        = 12;
    localparam int OUT_COL_W    = 11;
    localparam int KERNEL_TAPS  = 9;
    localparam int SUM_W        = 12;   // 9 * 255 = 2295
    localparam int RECIP_W      = 13;
    localparam int RECIP_SHIFT  = 16;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_DIM      = 3;

    // floor(x * 7282 / 2^16) == floor(x / 9) for all x <= 2295
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    // b in the low byte, r in the high byte
    typedef struct packed {
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] g;
        logic [DATA_W-1:0] b;
    } pix_t;

    typedef pix_t [KERNEL_TAPS-1:0] window_t;

    typedef logic [KERNEL_TAPS-1:0][DATA_W-1:0] chan_taps_t;

    // per-beat control that travels beside the window
    typedef struct packed {
        logic                 valid;
        logic                 emit;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } tap_ctl_t;

endpackage

// ----- src/bbx_ram.sv -----
module bbx_ram #(
    parameter int WIDTH = bbx_pkg::PIX_W,
    parameter int DEPTH = bbx_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and write at one address return the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bbx_window.sv -----
`include "rgb_box_blur_3x3_defines.svh"

module bbx_window #(
    parameter int MAX_WIDTH = bbx_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_accept,
    input  logic                                adv,
    input  bbx_pkg::pix_t                       in_px,
    input  logic [bbx_pkg::CFG_WIDTH_W-1:0]     cfg_width,
    input  logic [bbx_pkg::CFG_HEIGHT_W-1:0]    cfg_height,
    output bbx_pkg::window_t                    win,
    output bbx_pkg::tap_ctl_t                   win_ctl
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > bbx_pkg::CFG_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : bbx_pkg::CFG_WIDTH_W;
    localparam int HW  = bbx_pkg::CFG_HEIGHT_W;
    localparam int RW  = bbx_pkg::ROW_W;
    localparam logic [WW-1:0] W_MIN = WW'(bbx_pkg::MIN_DIM);
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
    localparam logic [HW-1:0] H_MIN = HW'(bbx_pkg::MIN_DIM);
    localparam logic [HW-1:0] H_MAX = HW'(bbx_pkg::MAX_HEIGHT);

    logic [WW-1:0] width_ext;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_col, last_row;

    bbx_pkg::tap_ctl_t ctl0, ctl1_reg, ctl2_reg;
    logic [CW-1:0]     c1_reg;
    bbx_pkg::pix_t     px1_reg;
    bbx_pkg::window_t  win_reg;

    logic [bbx_pkg::PIX_W-1:0] up_rd, mid_rd;

    // effective frame size, clamped
    assign width_ext = WW'(cfg_width);
    always_comb begin
        if (width_ext < W_MIN) begin
            w_eff = W_MIN;
        end else if (width_ext > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = width_ext;
        end
        if (cfg_height < H_MIN) begin
            h_eff = H_MIN;
        end else if (cfg_height > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = cfg_height;
        end
    end

    assign last_col = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign last_row = (HW'(row_reg) + HW'(1)) >= h_eff;

    always_comb begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RW'(1);
        end
    end

    always_comb begin
        ctl0.valid = in_accept;
        ctl0.emit  = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        ctl0.row   = row_reg - RW'(1);
        ctl0.col   = bbx_pkg::OUT_COL_W'(col_reg - CW'(1));
        ctl0.last  = last_row && last_col;
    end

    // middle store: read old row, write new pixel, same address
    bbx_ram #(.WIDTH(bbx_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .aclk  (aclk),
        .we    (in_accept),
        .waddr (col_reg),
        .wdata (in_px),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // upper store: writes the middle store's read word at column c1_reg once the pipe advances
    bbx_ram #(.WIDTH(bbx_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_up_ram (
        .aclk  (aclk),
        .we    (adv && ctl1_reg.valid),
        .waddr (c1_reg),
        .wdata (mid_rd),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (up_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            win_reg  <= '0;
        end else begin
            if (in_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv) begin
                ctl1_reg <= ctl0;
                ctl2_reg <= ctl1_reg;
                if (ctl1_reg.valid) begin
                    for (int i = 0; i < 3; i++) begin
                        win_reg[i*3]     <= win_reg[i*3+1];
                        win_reg[i*3 + 1] <= win_reg[i*3+2];
                    end
                    win_reg[2] <= up_rd;
                    win_reg[5] <= mid_rd;
                    win_reg[8] <= px1_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            c1_reg  <= col_reg;
            px1_reg <= in_px;
        end
    end

    assign win     = win_reg;
    assign win_ctl = ctl2_reg;

    `BBX_ASSERT_IMP(a_ram_no_collide, in_accept && ctl1_reg.valid, col_reg != c1_reg,
        "upper store read and write hit the same column")
    `BBX_ASSERT_IMP(a_col_in_store, 1'b1, WW'(col_reg) < W_MAX,
        "column count beyond line store depth")
    `BBX_ASSERT_NXT(a_row_wrap, in_accept && last_col, col_reg == '0,
        "column count did not wrap at end of row")

endmodule

// ----- src/bbx_lane.sv -----
module bbx_lane (
    input  logic                         aclk,
    input  logic                         en,
    input  bbx_pkg::chan_taps_t          taps,
    output logic [bbx_pkg::DATA_W-1:0]   mean
);

    localparam int PW = bbx_pkg::SUM_W + bbx_pkg::RECIP_W;

    logic [bbx_pkg::SUM_W-1:0] sum;
    logic [bbx_pkg::SUM_W-1:0] sum_reg;
    logic [PW-1:0]             prod;

    always_comb begin
        sum = '0;
        for (int i = 0; i < bbx_pkg::KERNEL_TAPS; i++) begin
            sum = sum + bbx_pkg::SUM_W'(taps[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum;
        end
    end

    // divide by 9 through the reciprocal
    assign prod = PW'(sum_reg) * PW'(bbx_pkg::RECIP_9);
    assign mean = prod[bbx_pkg::RECIP_SHIFT +: bbx_pkg::DATA_W];

endmodule

// ----- src/rgb_box_blur_3x3.sv -----
// 3x3 box blur over an RGB888 raster stream. Pixels enter one beat per clock
// on s_* (valid/ready) while the output is not stalled; every interior pixel
// yields one result beat on m_* carrying the truncated per-channel mean of
// its 3x3 neighborhood, its row and column, and m_last_of_frame on the final
// interior pixel of the frame. Border pixels give no result. The block
// sustains one pixel per clock while the output is drained, since each line
// store has its own write and read port. A result for the beat completing
// its window (the lower-right neighbor) reaches m_valid through these
// registered steps: the line store read at the accepting edge, then the
// window shift, the lane adder tree, and the reciprocal multiply into the
// output register. Frame size comes from image_width (byte address 0) and
// image_height (byte address 4) on the APB port, clamped to 3..MAX_WIDTH
// and 3..4096; write them only while the stream is idle. Line stores are
// not cleared after reset: the first two rows of a frame fill them.
`include "rgb_box_blur_3x3_defines.svh"

module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH = bbx_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bbx_pkg::PADDR_W-1:0]       paddr,
    input  logic [bbx_pkg::PDATA_W-1:0]       pwdata,
    output logic [bbx_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bbx_pkg::DATA_W-1:0]        s_pix_b,
    input  logic [bbx_pkg::DATA_W-1:0]        s_pix_g,
    input  logic [bbx_pkg::DATA_W-1:0]        s_pix_r,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bbx_pkg::DATA_W-1:0]        m_out_b,
    output logic [bbx_pkg::DATA_W-1:0]        m_out_g,
    output logic [bbx_pkg::DATA_W-1:0]        m_out_r,
    output logic [bbx_pkg::ROW_W-1:0]         m_out_row,
    output logic [bbx_pkg::OUT_COL_W-1:0]     m_out_col,
    output logic                              m_last_of_frame
);

    // ---------------- configuration registers ----------------
    logic [bbx_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [bbx_pkg::CFG_HEIGHT_W-1:0] height_reg;
    logic                             cfg_wr;
    bbx_pkg::reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = bbx_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bbx_pkg::WIDTH_RESET;
            height_reg <= bbx_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bbx_pkg::REG_WIDTH: begin
                    width_reg <= pwdata[bbx_pkg::CFG_WIDTH_W-1:0];
                end
                bbx_pkg::REG_HEIGHT: begin
                    height_reg <= pwdata[bbx_pkg::CFG_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bbx_pkg::REG_WIDTH:  prdata = bbx_pkg::PDATA_W'(width_reg);
            bbx_pkg::REG_HEIGHT: prdata = bbx_pkg::PDATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- pipeline flow ----------------
    // Every stage moves together whenever the output register is free or
    // being drained; that one enable is also the input ready.
    logic          m_valid_reg;
    logic          adv;
    logic          in_accept;
    bbx_pkg::pix_t in_px;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign in_accept = s_valid && adv;

    assign in_px.b = s_pix_b;
    assign in_px.g = s_pix_g;
    assign in_px.r = s_pix_r;

    // ---------------- line stores and 3x3 window ----------------
    bbx_pkg::window_t  win;
    bbx_pkg::tap_ctl_t win_ctl;

    bbx_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .adv        (adv),
        .in_px      (in_px),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .win        (win),
        .win_ctl    (win_ctl)
    );

    // ---------------- channel lanes ----------------
    // One lane per color: 9-tap sum, then divide by 9.
    bbx_pkg::chan_taps_t taps_b, taps_g, taps_r;
    logic [bbx_pkg::DATA_W-1:0] mean_b, mean_g, mean_r;
    logic lane_en;

    always_comb begin
        for (int i = 0; i < bbx_pkg::KERNEL_TAPS; i++) begin
            taps_b[i] = win[i].b;
            taps_g[i] = win[i].g;
            taps_r[i] = win[i].r;
        end
    end

    assign lane_en = adv && win_ctl.valid;

    bbx_lane u_lane_b (.aclk(aclk), .en(lane_en), .taps(taps_b), .mean(mean_b));
    bbx_lane u_lane_g (.aclk(aclk), .en(lane_en), .taps(taps_g), .mean(mean_g));
    bbx_lane u_lane_r (.aclk(aclk), .en(lane_en), .taps(taps_r), .mean(mean_r));

    // ---------------- merge into the output register ----------------
    bbx_pkg::tap_ctl_t ctl3_reg;
    logic              out_load;
    logic [bbx_pkg::DATA_W-1:0]    m_out_b_reg, m_out_g_reg, m_out_r_reg;
    logic [bbx_pkg::ROW_W-1:0]     m_out_row_reg;
    logic [bbx_pkg::OUT_COL_W-1:0] m_out_col_reg;
    logic                          m_last_reg;

    // border beats flow down the pipe but never reach the output
    assign out_load = adv && ctl3_reg.valid && ctl3_reg.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            ctl3_reg    <= win_ctl;
            m_valid_reg <= ctl3_reg.valid && ctl3_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_b_reg   <= mean_b;
            m_out_g_reg   <= mean_g;
            m_out_r_reg   <= mean_r;
            m_out_row_reg <= ctl3_reg.row;
            m_out_col_reg <= ctl3_reg.col;
            m_last_reg    <= ctl3_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_b         = m_out_b_reg;
    assign m_out_g         = m_out_g_reg;
    assign m_out_r         = m_out_r_reg;
    assign m_out_row       = m_out_row_reg;
    assign m_out_col       = m_out_col_reg;
    assign m_last_of_frame = m_last_reg;

    `BBX_ASSERT_NXT(a_emit_reaches_out, out_load, m_valid_reg,
        "interior beat lost before output")
    `BBX_ASSERT_NXT(a_no_phantom, adv && !(ctl3_reg.valid && ctl3_reg.emit), !m_valid_reg,
        "output beat without interior source")
    `BBX_ASSERT_IMP(a_out_row_interior, m_valid_reg, m_out_row_reg != '0,
        "result on border row")

endmodule
